### hw/rtl/dlpi_pkg.sv
// Shared widths, fixed-point constants and register indexes of the charge controller.
package dlpi_pkg;

    localparam int SAMPLE_W   = 16;                 // Q8.8 and Q2.14 fields
    localparam int GAIN_W     = 16;                 // gains, scaled 2^-20
    localparam int ERR_W      = SAMPLE_W + 1;       // signed difference of two samples
    localparam int PROD_W     = GAIN_W + 1 + ERR_W; // signed gain x error
    localparam int INTEG_W    = 40;                 // integrator width
    localparam int GAIN_FRAC  = 28;                 // fraction bits of a gain product
    localparam int REF_FRAC   = 8;                  // Q8.8
    localparam int DRIVE_FRAC = 14;                 // Q2.14
    localparam int CFG_IDX_W  = 3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_CURRENT_REF_FLOOR     = 3'd0;
    localparam cfg_idx_t CFG_DRIVE_MAX             = 3'd1;
    localparam cfg_idx_t CFG_DRIVE_MIN             = 3'd2;
    localparam cfg_idx_t CFG_VOLTAGE_INTEGRAL_GAIN = 3'd3;
    localparam cfg_idx_t CFG_CURRENT_PROP_GAIN     = 3'd4;
    localparam cfg_idx_t CFG_CURRENT_INTEGRAL_GAIN = 3'd5;

    localparam logic [SAMPLE_W-1:0] RST_CURRENT_REF_FLOOR     = 16'd0;
    localparam logic [SAMPLE_W-1:0] RST_DRIVE_MAX             = 16'd16384;
    localparam logic [SAMPLE_W-1:0] RST_DRIVE_MIN             = 16'd8192;
    localparam logic [GAIN_W-1:0]   RST_VOLTAGE_INTEGRAL_GAIN = 16'd2097;
    localparam logic [GAIN_W-1:0]   RST_CURRENT_PROP_GAIN     = 16'd0;
    localparam logic [GAIN_W-1:0]   RST_CURRENT_INTEGRAL_GAIN = 16'd1398;

endpackage

### hw/rtl/dlpi_sample_if.sv
// Input sample channel: valid/ready handshake with measurement payload.
interface dlpi_sample_if;
    logic                               valid;
    logic                               ready;
    logic [dlpi_pkg::SAMPLE_W-1:0]      battery_voltage;
    logic [dlpi_pkg::SAMPLE_W-1:0]      output_current;
    logic [dlpi_pkg::SAMPLE_W-1:0]      voltage_target;
    logic [dlpi_pkg::SAMPLE_W-1:0]      current_ceiling;
    logic                               loop_enable;

    modport source
    (
        output valid, battery_voltage, output_current, voltage_target, current_ceiling,
               loop_enable,
        input  ready
    );

    modport sink
    (
        input  valid, battery_voltage, output_current, voltage_target, current_ceiling,
               loop_enable,
        output ready
    );
endinterface

### hw/rtl/dlpi_result_if.sv
// Result channel: valid/ready handshake with drive and current reference payload.
interface dlpi_result_if;
    logic                               valid;
    logic                               ready;
    logic [dlpi_pkg::SAMPLE_W-1:0]      frequency_drive;
    logic [dlpi_pkg::SAMPLE_W-1:0]      current_reference;
    logic                               drive_clamped;

    modport source
    (
        output valid, frequency_drive, current_reference, drive_clamped,
        input  ready
    );

    modport sink
    (
        input  valid, frequency_drive, current_reference, drive_clamped,
        output ready
    );
endinterface

### hw/rtl/dlpi_mul_unit.sv
// Shared registered multiplier: unsigned gain times signed error.
module dlpi_mul_unit
(
    input  logic                                  clk,
    input  logic                                  en,
    input  logic [dlpi_pkg::GAIN_W-1:0]           gain,
    input  logic signed [dlpi_pkg::ERR_W-1:0]     err,
    output logic signed [dlpi_pkg::PROD_W-1:0]    product_reg
);

    logic signed [dlpi_pkg::PROD_W-1:0] product_next;

    assign product_next = $signed({1'b0, gain}) * err;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= product_next;
        end
    end

endmodule

### hw/rtl/dual_loop_pi_charge_controller_unit.sv
// Cascaded voltage/current PI charge controller, top level.
// An enabled sample steps through VMUL, VCLAMP, IERR, IMUL, PMUL and DCLAMP to DONE, a disabled
// one straight to DONE; the result loads once the output is free, and only IDLE takes a sample.
// The three gain products share one registered 17x17 multiplier, stepped by the sequencer.
// Reset (rst_n, async, active low): registers take their defaults, both integrators 1.0,
// no result pending, ready for a sample in the first cycle.
module dual_loop_pi_charge_controller_unit
#(
    parameter int INTEGRATOR_FRACTION_BITS = 20
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    dlpi_sample_if.sink                     sample,
    dlpi_result_if.source                   result,
    input  logic                            cfg_write,
    input  logic [dlpi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dlpi_pkg::SAMPLE_W-1:0]   cfg_data
);

    localparam int IW      = dlpi_pkg::INTEG_W;
    localparam int SW      = dlpi_pkg::SAMPLE_W;
    localparam int PW      = dlpi_pkg::PROD_W;
    localparam int PROD_SH = dlpi_pkg::GAIN_FRAC - INTEGRATOR_FRACTION_BITS;
    localparam int REF_SH  = INTEGRATOR_FRACTION_BITS - dlpi_pkg::REF_FRAC;
    localparam int DRV_SH  = INTEGRATOR_FRACTION_BITS - dlpi_pkg::DRIVE_FRAC;
    localparam int DRV_L   = (DRV_SH > 0) ? DRV_SH : 0;
    localparam int DRV_R   = (DRV_SH < 0) ? -DRV_SH : 0;
    localparam logic signed [IW-1:0] ONE_INTEG = IW'(1) << INTEGRATOR_FRACTION_BITS;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_VMUL,
        ST_VCLAMP,
        ST_IERR,
        ST_IMUL,
        ST_PMUL,
        ST_DCLAMP,
        ST_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic [SW-1:0]                  ref_floor_reg;
    logic [SW-1:0]                  drive_max_reg;
    logic [SW-1:0]                  drive_min_reg;
    logic [dlpi_pkg::GAIN_W-1:0]    vi_gain_reg;
    logic [dlpi_pkg::GAIN_W-1:0]    cp_gain_reg;
    logic [dlpi_pkg::GAIN_W-1:0]    ci_gain_reg;

    // loop state
    logic signed [IW-1:0]           vint_reg;
    logic signed [IW-1:0]           cint_reg;
    logic                           out_valid_reg;

    // per-sample working registers
    logic signed [dlpi_pkg::ERR_W-1:0] err_reg;
    logic signed [dlpi_pkg::ERR_W-1:0] err_next;
    logic [SW-1:0]                  iout_reg;
    logic [SW-1:0]                  ceil_reg;
    logic [SW-1:0]                  iref_reg;
    logic [SW-1:0]                  drive_reg;
    logic                           clamp_reg;
    logic signed [IW-1:0]           ci_reg;
    logic [SW-1:0]                  out_drive_reg;
    logic [SW-1:0]                  out_iref_reg;
    logic                           out_clamp_reg;

    // arithmetic
    logic                           mul_en;
    logic [dlpi_pkg::GAIN_W-1:0]    mul_gain;
    logic signed [PW-1:0]           product;
    logic signed [IW-1:0]           prod_scaled;
    logic signed [IW-1:0]           vi;
    logic signed [IW-1:0]           v_hi;
    logic signed [IW-1:0]           v_lo;
    logic signed [IW-1:0]           vi_shifted;
    logic signed [IW-1:0]           ci_sum;
    logic signed [IW-1:0]           co;
    logic signed [IW-1:0]           d_hi;
    logic signed [IW-1:0]           d_lo;
    logic signed [IW-1:0]           co_shifted;
    logic                           accept;
    logic                           out_load;

    assign accept   = sample.valid && sample.ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

    // shared multiplier: operand select follows the sequencer
    always_comb
    begin
        mul_en = 1'b0;
        mul_gain = vi_gain_reg;
        case (state_reg)
            ST_VMUL:
            begin
                mul_en = 1'b1;
                mul_gain = vi_gain_reg;
            end
            ST_IMUL:
            begin
                mul_en = 1'b1;
                mul_gain = ci_gain_reg;
            end
            ST_PMUL:
            begin
                mul_en = 1'b1;
                mul_gain = cp_gain_reg;
            end
            default:
            begin
                mul_en = 1'b0;
                mul_gain = vi_gain_reg;
            end
        endcase
    end

    dlpi_mul_unit u_mul
    (
        .clk         (clk),
        .en          (mul_en),
        .gain        (mul_gain),
        .err         (err_reg),
        .product_reg (product)
    );

    // product to 2^-F, floor
    assign prod_scaled = $signed({{(IW - PW){product[PW-1]}}, product}) >>> PROD_SH;

    // voltage loop
    assign vi         = vint_reg + prod_scaled;
    assign v_hi       = $signed(IW'(ceil_reg) << REF_SH);
    assign v_lo       = $signed(IW'(ref_floor_reg) << REF_SH);
    assign vi_shifted = vi >>> REF_SH;

    // current loop
    assign ci_sum     = cint_reg + prod_scaled;
    assign co         = prod_scaled + ci_reg;
    assign d_hi       = $signed((IW'(drive_max_reg) << DRV_L) >> DRV_R);
    assign d_lo       = $signed((IW'(drive_min_reg) << DRV_L) >> DRV_R);
    assign co_shifted = (co <<< DRV_R) >>> DRV_L;

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            err_next = $signed({1'b0, sample.voltage_target})
                     - $signed({1'b0, sample.battery_voltage});
        end
        else
        begin
            err_next = $signed({1'b0, iout_reg}) - $signed({1'b0, iref_reg});
        end
    end

    assign sample.ready             = (state_reg == ST_IDLE);
    assign result.valid             = out_valid_reg;
    assign result.frequency_drive   = out_drive_reg;
    assign result.current_reference = out_iref_reg;
    assign result.drive_clamped     = out_clamp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            vint_reg      <= ONE_INTEG;
            cint_reg      <= ONE_INTEG;
            ref_floor_reg <= dlpi_pkg::RST_CURRENT_REF_FLOOR;
            drive_max_reg <= dlpi_pkg::RST_DRIVE_MAX;
            drive_min_reg <= dlpi_pkg::RST_DRIVE_MIN;
            vi_gain_reg   <= dlpi_pkg::RST_VOLTAGE_INTEGRAL_GAIN;
            cp_gain_reg   <= dlpi_pkg::RST_CURRENT_PROP_GAIN;
            ci_gain_reg   <= dlpi_pkg::RST_CURRENT_INTEGRAL_GAIN;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    dlpi_pkg::CFG_CURRENT_REF_FLOOR:     ref_floor_reg <= cfg_data;
                    dlpi_pkg::CFG_DRIVE_MAX:             drive_max_reg <= cfg_data;
                    dlpi_pkg::CFG_DRIVE_MIN:             drive_min_reg <= cfg_data;
                    dlpi_pkg::CFG_VOLTAGE_INTEGRAL_GAIN: vi_gain_reg   <= cfg_data;
                    dlpi_pkg::CFG_CURRENT_PROP_GAIN:     cp_gain_reg   <= cfg_data;
                    dlpi_pkg::CFG_CURRENT_INTEGRAL_GAIN: ci_gain_reg   <= cfg_data;
                    default:                             ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (sample.loop_enable)
                        begin
                            state_reg <= ST_VMUL;
                        end
                        else
                        begin
                            cint_reg  <= d_hi;
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_VMUL:   state_reg <= ST_VCLAMP;
                ST_VCLAMP:
                begin
                    // anti-windup: keep integrator when the reference is clamped
                    if (!(vi > v_hi) && !(vi < v_lo))
                    begin
                        vint_reg <= vi;
                    end
                    state_reg <= ST_IERR;
                end
                ST_IERR:   state_reg <= ST_IMUL;
                ST_IMUL:   state_reg <= ST_PMUL;
                ST_PMUL:   state_reg <= ST_DCLAMP;
                ST_DCLAMP:
                begin
                    if (!(co > d_hi) && !(co < d_lo))
                    begin
                        cint_reg <= ci_reg;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            iout_reg  <= sample.output_current;
            ceil_reg  <= sample.current_ceiling;
            err_reg   <= err_next;
            iref_reg  <= '0;
            drive_reg <= drive_max_reg;
            clamp_reg <= 1'b0;
        end

        if (state_reg == ST_VCLAMP)
        begin
            if (vi > v_hi)
            begin
                iref_reg <= ceil_reg;
            end
            else if (vi < v_lo)
            begin
                iref_reg <= ref_floor_reg;
            end
            else
            begin
                iref_reg <= vi_shifted[SW-1:0];
            end
        end

        if (state_reg == ST_IERR)
        begin
            err_reg <= err_next;
        end

        if (state_reg == ST_PMUL)
        begin
            ci_reg <= ci_sum;
        end

        if (state_reg == ST_DCLAMP)
        begin
            if (co > d_hi)
            begin
                drive_reg <= drive_max_reg;
                clamp_reg <= 1'b1;
            end
            else if (co < d_lo)
            begin
                drive_reg <= drive_min_reg;
                clamp_reg <= 1'b1;
            end
            else
            begin
                drive_reg <= co_shifted[SW-1:0];
                clamp_reg <= 1'b0;
            end
        end

        if (out_load)
        begin
            out_drive_reg <= drive_reg;
            out_iref_reg  <= iref_reg;
            out_clamp_reg <= clamp_reg;
        end
    end

`ifndef SYNTHESIS
    // integrators only ever take values inside non-negative clamps
    a_vint_nonneg: assert property (@(posedge clk) disable iff (!rst_n) !vint_reg[IW-1])
        else $error("voltage integrator went negative");

    a_cint_nonneg: assert property (@(posedge clk) disable iff (!rst_n) !cint_reg[IW-1])
        else $error("current integrator went negative");

    a_disable_forces_max: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !sample.loop_enable) |=> (state_reg == ST_DONE && cint_reg == d_hi))
        else $error("disabled sample did not force the current integrator to the maximum");

    a_clamp_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.drive_clamped) |->
            (result.frequency_drive == drive_max_reg || result.frequency_drive == drive_min_reg))
        else $error("clamped drive is not at a limit");
`endif

endmodule

### test/tb_top.sv
// Self-checking testbench for the cascaded voltage/current PI charge controller.
`timescale 1ns / 100ps

module tb_top;

    localparam int SW          = dlpi_pkg::SAMPLE_W;
    localparam int FRAC        = 20;
    localparam int REF_SH      = FRAC - dlpi_pkg::REF_FRAC;
    localparam int DRV_SH      = FRAC - dlpi_pkg::DRIVE_FRAC;
    localparam int PROD_SH     = FRAC - dlpi_pkg::GAIN_FRAC;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 16;
    localparam int PHASE_ITEMS = 190;

    typedef enum {SHAPED, NOISE} sample_style_t;

    typedef struct packed {
        logic [SW-1:0] battery_voltage;
        logic [SW-1:0] output_current;
        logic [SW-1:0] voltage_target;
        logic [SW-1:0] current_ceiling;
        logic          loop_enable;
    } sample_t;

    typedef struct packed {
        logic [SW-1:0] frequency_drive;
        logic [SW-1:0] current_reference;
        logic          drive_clamped;
    } drive_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write;
    dlpi_pkg::cfg_idx_t cfg_index;
    logic [SW-1:0]      cfg_data;

    dlpi_sample_if smp();
    dlpi_result_if res();

    dual_loop_pi_charge_controller_unit #(.INTEGRATOR_FRACTION_BITS(FRAC)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (smp),
        .result    (res),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // controller copy: registers and both integrators (2^-FRAC scaling)
    logic [SW-1:0]       ref_floor, drv_max, drv_min, v_ki, i_kp, i_ki;
    longint              v_acc, i_acc;

    sample_t             sample_q[$];
    drive_result_t       drive_q[$];
    sample_t             next_sample;
    drive_result_t       want;
    int unsigned         src_idle_pct, sink_stall_pct;
    int                  fail_count;
    int                  cycle_count;
    int                  samples_sent, results_seen;

    initial
    begin
        forever #1 clk = ~clk;
    end

    // x * 2^sh, or floor(x / 2^-sh) for negative sh
    function automatic longint pow2(longint x, int sh);
        if (sh >= 0)
            return x <<< sh;
        return x >>> (-sh);
    endfunction

    function automatic longint gain_err(longint gain, longint err);
        return pow2(gain * err, PROD_SH);
    endfunction

    function automatic drive_result_t run_loops(sample_t s);
        longint        vi, hi, lo, iref, err, ci, co, dhi, dlo, dq;
        drive_result_t r;
        r = '0;
        if (!s.loop_enable)
        begin
            i_acc = pow2(longint'(drv_max), DRV_SH);
            r.frequency_drive = drv_max;
        end
        else
        begin
            // outer loop: integral only, conditional anti-windup
            vi = v_acc + gain_err(longint'(v_ki),
                                  longint'(s.voltage_target) - longint'(s.battery_voltage));
            hi = pow2(longint'(s.current_ceiling), REF_SH);
            lo = pow2(longint'(ref_floor), REF_SH);
            if (vi > hi)
                iref = longint'(s.current_ceiling);
            else if (vi < lo)
                iref = longint'(ref_floor);
            else
            begin
                v_acc = vi;
                iref = pow2(vi, -REF_SH) & 64'hFFFF;
            end
            r.current_reference = iref[SW-1:0];

            // inner loop on the reported Q8.8 reference
            err = longint'(s.output_current) - iref;
            ci = i_acc + gain_err(longint'(i_ki), err);
            co = gain_err(longint'(i_kp), err) + ci;
            dhi = pow2(longint'(drv_max), DRV_SH);
            dlo = pow2(longint'(drv_min), DRV_SH);
            if (co > dhi)
            begin
                r.frequency_drive = drv_max;
                r.drive_clamped = 1'b1;
            end
            else if (co < dlo)
            begin
                r.frequency_drive = drv_min;
                r.drive_clamped = 1'b1;
            end
            else
            begin
                i_acc = ci;
                dq = pow2(co, -DRV_SH);
                r.frequency_drive = dq[SW-1:0];
            end
        end
        return r;
    endfunction

    function automatic sample_t random_sample(sample_style_t style);
        sample_t     s;
        int          vt, cc, oc;
        logic [95:0] rnd;
        rnd = {$urandom, $urandom, $urandom};
        s = rnd[$bits(sample_t)-1:0];
        if (style == SHAPED)
        begin
            // near-target voltage, current close to a reachable ceiling
            vt = $urandom_range(20000, 8000);
            cc = int'(ref_floor) + int'($urandom_range(3000, 0));
            cc = (cc > 65535) ? 65535 : cc;
            oc = cc + int'($urandom_range(400, 0)) - 200;
            oc = (oc < 0) ? 0 : ((oc > 65535) ? 65535 : oc);
            s.voltage_target  = SW'(vt);
            s.battery_voltage = SW'(vt + int'($urandom_range(600, 0)) - 300);
            s.current_ceiling = SW'(cc);
            s.output_current  = SW'(oc);
            s.loop_enable     = ($urandom_range(15, 0) != 0);
        end
        return s;
    endfunction

    task automatic enqueue(sample_t s);
        sample_q.push_back(s);
        samples_sent++;
    endtask

    task automatic set_reg(dlpi_pkg::cfg_idx_t idx, logic [SW-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            dlpi_pkg::CFG_CURRENT_REF_FLOOR:     ref_floor = value;
            dlpi_pkg::CFG_DRIVE_MAX:             drv_max = value;
            dlpi_pkg::CFG_DRIVE_MIN:             drv_min = value;
            dlpi_pkg::CFG_VOLTAGE_INTEGRAL_GAIN: v_ki = value;
            dlpi_pkg::CFG_CURRENT_PROP_GAIN:     i_kp = value;
            dlpi_pkg::CFG_CURRENT_INTEGRAL_GAIN: i_ki = value;
            default: ;
        endcase
    endtask

    task automatic configure(logic [SW-1:0] floor_v, logic [SW-1:0] dmax_v,
                             logic [SW-1:0] dmin_v, logic [SW-1:0] vki_v,
                             logic [SW-1:0] kp_v, logic [SW-1:0] ki_v);
        set_reg(dlpi_pkg::CFG_CURRENT_REF_FLOOR, floor_v);
        set_reg(dlpi_pkg::CFG_DRIVE_MAX, dmax_v);
        set_reg(dlpi_pkg::CFG_DRIVE_MIN, dmin_v);
        set_reg(dlpi_pkg::CFG_VOLTAGE_INTEGRAL_GAIN, vki_v);
        set_reg(dlpi_pkg::CFG_CURRENT_PROP_GAIN, kp_v);
        set_reg(dlpi_pkg::CFG_CURRENT_INTEGRAL_GAIN, ki_v);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // wait for every queued sample to come back, then let the pipeline settle
    task automatic drain();
        while (results_seen < samples_sent)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        int dmax;
        cfg_write = 1'b0;
        cfg_index = dlpi_pkg::CFG_CURRENT_REF_FLOOR;
        cfg_data  = '0;
        ref_floor = dlpi_pkg::RST_CURRENT_REF_FLOOR;
        drv_max   = dlpi_pkg::RST_DRIVE_MAX;
        drv_min   = dlpi_pkg::RST_DRIVE_MIN;
        v_ki      = dlpi_pkg::RST_VOLTAGE_INTEGRAL_GAIN;
        i_kp      = dlpi_pkg::RST_CURRENT_PROP_GAIN;
        i_ki      = dlpi_pkg::RST_CURRENT_INTEGRAL_GAIN;
        v_acc = longint'(1) <<< FRAC;
        i_acc = pow2(longint'(dlpi_pkg::RST_DRIVE_MAX), DRV_SH);
        src_idle_pct = 0;
        sink_stall_pct = 0;
        fail_count = 0;
        samples_sent = 0;
        results_seen = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: full-scale errors, zero ceiling, disabled samples
        enqueue({16'd0,     16'd0,     16'hFFFF,  16'hFFFF,  1'b1});
        enqueue({16'hFFFF,  16'hFFFF,  16'd0,     16'hFFFF,  1'b1});
        enqueue({16'd0,     16'd0,     16'd0,     16'd0,     1'b1});
        enqueue({16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1});
        enqueue({16'd3000,  16'd256,   16'd3000,  16'd1000,  1'b1});
        enqueue({16'd0,     16'd50,    16'd100,   16'd0,     1'b1});
        enqueue({16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b0});
        enqueue({16'hA5A5,  16'h5A5A,  16'h0F0F,  16'hF0F0,  1'b0});
        drain();

        // floor above ceiling, drive_max below drive_min, full gains
        configure(16'd40000, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        enqueue({16'd1000,  16'd200,   16'd1200,  16'd100,   1'b1});
        enqueue({16'd5000,  16'd9000,  16'd5000,  16'hFFFF,  1'b1});
        enqueue({16'hFFFF,  16'd0,     16'd0,     16'hFFFF,  1'b1});
        enqueue({16'd0,     16'hFFFF,  16'hFFFF,  16'd20000, 1'b0});
        drain();

        // widest drive window, zero gains
        configure(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
        enqueue({16'd2000,  16'd300,   16'd2100,  16'd800,   1'b1});
        enqueue({16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1});
        enqueue({16'd0,     16'd0,     16'd0,     16'd0,     1'b1});
        drain();

        // equal drive limits, floor equal to the first sample's ceiling
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1);
        enqueue({16'd100,   16'd200,   16'd300,   16'hFFFF,  1'b1});
        enqueue({16'd4000,  16'd0,     16'd3000,  16'd0,     1'b1});
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph % 2 == 0)
            begin
                dmax = $urandom_range(40000, 12000);
                configure(SW'($urandom_range(1500, 0)), SW'(dmax),
                          SW'($urandom_range(dmax - 1000, 2000)),
                          SW'($urandom_range(20000, 0)), SW'($urandom_range(20000, 0)),
                          SW'($urandom_range(20000, 0)));
            end
            else
                configure(SW'($urandom), SW'($urandom), SW'($urandom), SW'($urandom),
                          SW'($urandom), SW'($urandom));
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 72; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 72; end
                default: begin src_idle_pct = 7; sink_stall_pct = 7; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                enqueue(random_sample(($urandom_range(4, 0) == 0) ? NOISE : SHAPED));
            drain();
        end

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp.valid           <= 1'b0;
            smp.battery_voltage <= '0;
            smp.output_current  <= '0;
            smp.voltage_target  <= '0;
            smp.current_ceiling <= '0;
            smp.loop_enable     <= 1'b0;
        end
        else if (!smp.valid || smp.ready)
        begin
            if (sample_q.size() != 0 && $urandom_range(99, 0) >= src_idle_pct)
            begin
                next_sample = sample_q.pop_front();
                smp.battery_voltage <= next_sample.battery_voltage;
                smp.output_current  <= next_sample.output_current;
                smp.voltage_target  <= next_sample.voltage_target;
                smp.current_ceiling <= next_sample.current_ceiling;
                smp.loop_enable     <= next_sample.loop_enable;
                smp.valid <= 1'b1;
            end
            else
                smp.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else
            res.ready <= ($urandom_range(99, 0) >= sink_stall_pct);
    end

    // result check first, then prediction of the sample taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                results_seen++;
                if (drive_q.size() == 0)
                begin
                    $error("result transaction with no sample outstanding");
                    fail_count++;
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (res.frequency_drive !== want.frequency_drive)
                    begin
                        $error("frequency_drive: expected %0d, got %0d",
                               want.frequency_drive, res.frequency_drive);
                        fail_count++;
                    end
                    if (res.current_reference !== want.current_reference)
                    begin
                        $error("current_reference: expected %0d, got %0d",
                               want.current_reference, res.current_reference);
                        fail_count++;
                    end
                    if (res.drive_clamped !== want.drive_clamped)
                    begin
                        $error("drive_clamped: expected %0d, got %0d",
                               want.drive_clamped, res.drive_clamped);
                        fail_count++;
                    end
                end
            end
            if (smp.valid && smp.ready)
                drive_q.push_back(run_loops({smp.battery_voltage, smp.output_current,
                                             smp.voltage_target, smp.current_ceiling,
                                             smp.loop_enable}));
        end
    end

endmodule
